[design/rbe_pkg.sv]
// types and constants shared by the report-by-exception deadband block
// no dependencies; every other design file but rbe_rsp_if refers to it by scoped names

package rbe_pkg;

   // snapshot item modes
   typedef enum logic [1:0] {
      MODE_CHECK  = 2'd0,
      MODE_RECORD = 2'd1,
      MODE_RESET  = 2'd2,
      MODE_IGNORE = 2'd3
   } rbe_mode_type;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_FIRST = 3'd1;
   localparam int DEADBAND_COUNT = 6;
   localparam int DEADBAND_W = 31;
   localparam logic [31:0] FORCE_INTERVAL_RESET = 32'd60000;

   // one input word, packed
   typedef struct packed {
      rbe_mode_type       mode;
      logic [4:0]         channel;
      logic [2:0]         measurement_kind;
      logic               supported;
      logic signed [31:0] sample_value;
      logic               sample_valid;
      logic               sample_stale;
      logic [2:0]         liveness_flags;
      logic [15:0]        status_code;
      logic [47:0]        now_ms;
      logic               last_item;
   } rbe_req_type;

   // published reference of one channel
   typedef struct packed {
      logic signed [31:0] value;
      logic               valid;
      logic               stale;
   } rbe_sample_type;

   // channel table update controls
   typedef struct packed {
      logic clear_all;
      logic wr_en;
   } rbe_tbl_ctl_type;

   // snapshot tracking status
   typedef struct packed {
      logic ever_published;
      logic mid_snapshot;
   } rbe_snap_stat_type;

endpackage

[design/rbe_req_if.sv]
// input channel: valid/ready handshake carrying one channel item
// uses rbe_pkg for the mode type

interface rbe_req_if;
   logic                 valid;
   logic                 ready;
   rbe_pkg::rbe_mode_type mode;
   logic [4:0]           channel;
   logic [2:0]           measurement_kind;
   logic                 supported;
   logic signed [31:0]   sample_value;
   logic                 sample_valid;
   logic                 sample_stale;
   logic [2:0]           liveness_flags;
   logic [15:0]          status_code;
   logic [47:0]          now_ms;
   logic                 last_item;

   modport source (
      output valid, mode, channel, measurement_kind, supported, sample_value,
         sample_valid, sample_stale, liveness_flags, status_code, now_ms, last_item,
      input  ready
   );
   modport sink (
      input  valid, mode, channel, measurement_kind, supported, sample_value,
         sample_valid, sample_stale, liveness_flags, status_code, now_ms, last_item,
      output ready
   );
endinterface

[design/rbe_rsp_if.sv]
// result channel: valid/ready handshake carrying the publish decision
// no dependencies

interface rbe_rsp_if;
   logic valid;
   logic ready;
   logic publish;

   modport source (output valid, publish, input ready);
   modport sink (input valid, publish, output ready);
endinterface

[design/rbe_csr.sv]
// configuration registers: force interval and per-kind deadbands
// uses rbe_pkg for register indexes and reset values

module rbe_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rbe_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rbe_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [2:0]                           kind,
   output logic [31:0]                          force_interval,
   output logic [rbe_pkg::DEADBAND_W-1:0]        band
);

   logic [31:0]                   force_interval_ff;
   logic [rbe_pkg::DEADBAND_W-1:0] deadband_ff [rbe_pkg::DEADBAND_COUNT];

   // register writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         force_interval_ff <= rbe_pkg::FORCE_INTERVAL_RESET;
         for (int i = 0; i < rbe_pkg::DEADBAND_COUNT; i++) begin
            deadband_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == rbe_pkg::CSR_FORCE_INTERVAL) begin
            force_interval_ff <= csr_wdata;
         end
         for (int i = 0; i < rbe_pkg::DEADBAND_COUNT; i++) begin
            if (csr_index == rbe_pkg::CSR_IDX_W'(rbe_pkg::CSR_DEADBAND_FIRST + i)) begin
               deadband_ff[i] <= csr_wdata[rbe_pkg::DEADBAND_W-1:0];
            end
         end
      end
   end

   // deadband of the item's kind, kinds past the list get zero
   always_comb begin
      band = '0;
      for (int i = 0; i < rbe_pkg::DEADBAND_COUNT; i++) begin
         if (kind == 3'(i)) begin
            band = deadband_ff[i];
         end
      end
   end

   assign force_interval = force_interval_ff;

endmodule

[design/rbe_chan_table.sv]
// channel table: presence bits in flops plus published sample memory
// uses rbe_pkg for the sample and control types

module rbe_chan_table #(
   parameter int CHANNELS = 32,
   parameter int IDX_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rbe_pkg::rbe_tbl_ctl_type ctl,
   input  logic [IDX_W-1:0]        wr_idx,
   input  rbe_pkg::rbe_sample_type  wr_sample,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_idx,
   output rbe_pkg::rbe_sample_type  rd_sample,
   input  logic [IDX_W-1:0]        chk_idx,
   output logic                    chk_present
);

   logic                   present_ff [CHANNELS];
   rbe_pkg::rbe_sample_type sample_mem [CHANNELS];
   rbe_pkg::rbe_sample_type rd_sample_ff;

   // presence bits: clear all, then mark the written entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            present_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            present_ff[i] <= (present_ff[i] && !ctl.clear_all) ||
               (ctl.wr_en && (wr_idx == IDX_W'(i)));
         end
      end
   end

   // sample memory write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         sample_mem[wr_idx] <= wr_sample;
      end
   end

   // registered read, bypassing a write to the same entry at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (ctl.wr_en && (wr_idx == rd_idx)) begin
            rd_sample_ff <= wr_sample;
         end else begin
            rd_sample_ff <= sample_mem[rd_idx];
         end
      end
   end

   assign rd_sample   = rd_sample_ff;
   assign chk_present = present_ff[chk_idx];

endmodule

[design/rbe_snapshot.sv]
// snapshot-level state and the publish decision of a check snapshot
// uses rbe_pkg for the item word, mode codes and status struct

module rbe_snapshot (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  rbe_pkg::rbe_req_type       item,
   input  logic                      chan_hit,
   input  logic [31:0]               force_interval,
   output logic                      publish,
   output rbe_pkg::rbe_snap_stat_type stat
);

   logic        ever_published_ff;
   logic [47:0] last_publish_time_ff;
   logic [2:0]  published_liveness_ff;
   logic [15:0] published_status_ff;
   logic        change_seen_ff;
   logic        mid_snapshot_ff;

   logic        change_base;
   logic        change_new;
   logic [47:0] elapsed;
   logic        time_back;
   logic        forced;

   // change flag restarts on the first word of a snapshot
   assign change_base = mid_snapshot_ff && change_seen_ff;
   assign change_new  = change_base || chan_hit;

   // time checks; elapsed only matters when time did not go back
   assign elapsed   = item.now_ms - last_publish_time_ff;
   assign time_back = item.now_ms < last_publish_time_ff;
   assign forced    = elapsed >= {16'd0, force_interval};

   assign publish = !ever_published_ff ||
      (item.liveness_flags != published_liveness_ff) ||
      (item.status_code != published_status_ff) ||
      time_back || forced || change_new;

   // state update per executed word
   always_ff @(posedge clock) begin
      if (reset) begin
         ever_published_ff     <= 1'b0;
         last_publish_time_ff  <= '0;
         published_liveness_ff <= '0;
         published_status_ff   <= '0;
         change_seen_ff        <= 1'b0;
         mid_snapshot_ff       <= 1'b0;
      end else if (fire) begin
         unique case (item.mode)
            rbe_pkg::MODE_RESET: begin
               ever_published_ff    <= 1'b0;
               last_publish_time_ff <= '0;
               change_seen_ff       <= 1'b0;
               mid_snapshot_ff      <= 1'b0;
            end
            rbe_pkg::MODE_RECORD: begin
               mid_snapshot_ff <= !item.last_item;
               if (item.last_item) begin
                  last_publish_time_ff  <= item.now_ms;
                  ever_published_ff     <= 1'b1;
                  published_liveness_ff <= item.liveness_flags;
                  published_status_ff   <= item.status_code;
                  change_seen_ff        <= 1'b0;
               end else begin
                  change_seen_ff <= change_base;
               end
            end
            rbe_pkg::MODE_CHECK: begin
               mid_snapshot_ff <= !item.last_item;
               change_seen_ff  <= !item.last_item && change_new;
            end
            default: begin
            end
         endcase
      end
   end

   assign stat.ever_published = ever_published_ff;
   assign stat.mid_snapshot   = mid_snapshot_ff;

endmodule

[design/deadband_report_by_exception_top.sv]
// top level of the report-by-exception deadband block
// uses rbe_pkg, rbe_req_if, rbe_rsp_if, rbe_csr, rbe_chan_table and rbe_snapshot
//
//   port      dir   handshake          contents
//   req_ch    in    valid/ready        one channel item of a snapshot
//   rsp_ch    out   valid/ready        publish decision of a check snapshot
//   csr_*     in    write enable only  force interval and six deadbands
//
// one word per cycle unless stalled: a word is registered on accept, evaluated in
// the next cycle against the channel table and snapshot state, and its decision
// is registered in the result register as the word leaves the stage; the sample
// memory read is registered with the input word. reset is synchronous and clears
// all control state and presence bits at once. the input stalls only while a
// finished decision waits in the result register and the staged word also produces one.

module deadband_report_by_exception_top #(
   parameter int CHANNELS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   rbe_req_if.sink                       req_ch,
   rbe_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [rbe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   rbe_pkg::rbe_req_type       req_word;
   rbe_pkg::rbe_req_type       s1_item_ff;
   logic                      s1_valid_ff;
   logic                      rsp_valid_ff;
   logic                      publish_ff;

   logic                      req_fire;
   logic                      s1_emit;
   logic                      s1_go;
   logic                      s1_fire;
   logic                      s1_usable;
   logic [IDX_W-1:0]          s1_idx;
   logic [IDX_W-1:0]          rd_idx;
   logic                      present;
   logic                      eff_present;
   rbe_pkg::rbe_sample_type    rec;
   rbe_pkg::rbe_sample_type    wr_sample;
   rbe_pkg::rbe_tbl_ctl_type   tbl_ctl;
   rbe_pkg::rbe_snap_stat_type stat;
   logic [31:0]               force_interval;
   logic [rbe_pkg::DEADBAND_W-1:0] band;
   logic signed [32:0]        diff;
   logic [32:0]               mag;
   logic                      hit;
   logic                      chan_hit;
   logic                      publish;

   // pack the input word
   always_comb begin
      req_word.mode             = req_ch.mode;
      req_word.channel          = req_ch.channel;
      req_word.measurement_kind = req_ch.measurement_kind;
      req_word.supported        = req_ch.supported;
      req_word.sample_value     = req_ch.sample_value;
      req_word.sample_valid     = req_ch.sample_valid;
      req_word.sample_stale     = req_ch.sample_stale;
      req_word.liveness_flags   = req_ch.liveness_flags;
      req_word.status_code      = req_ch.status_code;
      req_word.now_ms           = req_ch.now_ms;
      req_word.last_item        = req_ch.last_item;
   end

   // handshake and stage advance
   assign s1_emit  = (s1_item_ff.mode == rbe_pkg::MODE_CHECK) && s1_item_ff.last_item;
   assign s1_go    = !s1_emit || !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire  = s1_valid_ff && s1_go;
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_fire = req_ch.valid && req_ch.ready;

   // input stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_word;
      end
   end

   // configuration
   rbe_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .kind           (s1_item_ff.measurement_kind),
      .force_interval (force_interval),
      .band           (band)
   );

   // table addressing; out-of-range channels are treated as unsupported
   assign rd_idx    = IDX_W'(req_ch.channel);
   assign s1_idx    = IDX_W'(s1_item_ff.channel);
   assign s1_usable = s1_item_ff.supported && (32'(s1_item_ff.channel) < CHANNELS);

   // a record snapshot starts from an empty table
   assign eff_present = present && stat.mid_snapshot;

   assign tbl_ctl.clear_all = s1_fire && ((s1_item_ff.mode == rbe_pkg::MODE_RESET) ||
      ((s1_item_ff.mode == rbe_pkg::MODE_RECORD) && !stat.mid_snapshot));
   assign tbl_ctl.wr_en = s1_fire && (s1_item_ff.mode == rbe_pkg::MODE_RECORD) &&
      s1_usable && !eff_present;

   assign wr_sample.value = s1_item_ff.sample_value;
   assign wr_sample.valid = s1_item_ff.sample_valid;
   assign wr_sample.stale = s1_item_ff.sample_stale;

   rbe_chan_table #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (tbl_ctl),
      .wr_idx      (s1_idx),
      .wr_sample   (wr_sample),
      .rd_en       (req_fire),
      .rd_idx      (rd_idx),
      .rd_sample   (rec),
      .chk_idx     (s1_idx),
      .chk_present (present)
   );

   // per-channel change against the published reference
   assign diff = {s1_item_ff.sample_value[31], s1_item_ff.sample_value} -
      {rec.value[31], rec.value};
   assign mag  = diff[32] ? 33'(~diff + 33'd1) : 33'(diff);
   assign hit  = !present ||
      (rec.valid != s1_item_ff.sample_valid) ||
      (rec.stale != s1_item_ff.sample_stale) ||
      (s1_item_ff.sample_valid && (mag > {2'b00, band}));
   assign chan_hit = (s1_item_ff.mode == rbe_pkg::MODE_CHECK) && s1_usable && hit;

   rbe_snapshot u_snapshot (
      .clock          (clock),
      .reset          (reset),
      .fire           (s1_fire),
      .item           (s1_item_ff),
      .chan_hit       (chan_hit),
      .force_interval (force_interval),
      .publish        (publish),
      .stat           (stat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_emit) begin
         publish_ff <= publish;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.publish = publish_ff;

   // a check last word always lands in the result register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_emit) |=> rsp_valid_ff)
      else $error("decision of a check snapshot was lost");

   // input back-pressure only from a full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s1_emit && rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a pending decision");

   // a reset word leaves nothing published and no open snapshot
   a_reset_word: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_item_ff.mode == rbe_pkg::MODE_RESET)) |=>
      (!stat.ever_published && !stat.mid_snapshot))
      else $error("reset word did not clear snapshot state");

endmodule
